/* rtl/core/bhd_pkg.sv */
package bhd_pkg;

    // width of the internal decoded byte counter
    localparam int LENGTH_BITS = 16;
    localparam int OUT_LENGTH_BITS = 16;

    // op queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F = 8'h66;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_OK = 2'd1;
    localparam logic [1:0] KIND_ERR = 2'd2;

    typedef enum logic [2:0] {
        MODE_PLAIN,
        MODE_ESC,
        MODE_HEX1,
        MODE_DONE,
        MODE_ERROR
    } mode_t;

    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [1:0]                 out_kind;
        logic [7:0]                 out_byte;
        logic [OUT_LENGTH_BITS-1:0] out_length;
        logic                       out_end;
    } out_item_t;

    // one accepted character turned into at most two results
    typedef struct packed {
        logic                       has_byte;
        logic [7:0]                 data_byte;
        logic                       has_close;
        logic                       close_err;
        logic [OUT_LENGTH_BITS-1:0] length;
    } op_t;

    // queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic not_empty;
    } queue_status_t;

    // returns {valid, nibble}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9)
        begin
            r = {1'b1, 4'(c - CHAR_DIGIT_0)};
        end
        else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)
        begin
            r = {1'b1, 4'(c - CHAR_UPPER_A + 8'd10)};
        end
        else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F)
        begin
            r = {1'b1, 4'(c - CHAR_LOWER_A + 8'd10)};
        end
        return r;
    endfunction

endpackage

/* rtl/core/bhd_front.sv */
module bhd_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  bhd_pkg::in_item_t       in_data,
    input  bhd_pkg::queue_status_t  queue_status,
    output logic                    push,
    output bhd_pkg::op_t            push_op
);

    bhd_pkg::mode_t                     mode_reg, mode_next;
    logic [3:0]                         nibble_reg, nibble_next;
    logic [bhd_pkg::LENGTH_BITS-1:0]    count_reg, count_next;

    logic                               accept;
    logic                               emit;
    logic [7:0]                         emit_byte;
    logic [4:0]                         hv;
    bhd_pkg::mode_t                     mode_step;
    logic [3:0]                         nibble_step;
    logic [bhd_pkg::LENGTH_BITS-1:0]    count_step;

    function automatic logic [bhd_pkg::OUT_LENGTH_BITS-1:0] sat_length(
        input logic [bhd_pkg::LENGTH_BITS-1:0] cnt);
        logic [31:0] ext;
        ext = 32'(cnt);
        if (ext > 32'h0000_FFFF)
        begin
            return '1;
        end
        return ext[bhd_pkg::OUT_LENGTH_BITS-1:0];
    endfunction

    assign in_ready = !queue_status.full;
    assign accept = in_valid && in_ready;
    assign hv = bhd_pkg::hex_value(in_data.in_char);

    always_comb
    begin
        mode_step = mode_reg;
        nibble_step = nibble_reg;
        emit = 1'b0;
        emit_byte = '0;
        unique case (mode_reg)
            bhd_pkg::MODE_PLAIN:
            begin
                if (in_data.in_char == bhd_pkg::CHAR_NUL)
                begin
                    mode_step = bhd_pkg::MODE_DONE;
                end
                else if (in_data.in_char == bhd_pkg::CHAR_BACKSLASH)
                begin
                    mode_step = bhd_pkg::MODE_ESC;
                end
                else
                begin
                    emit = 1'b1;
                    emit_byte = in_data.in_char;
                end
            end
            bhd_pkg::MODE_ESC:
            begin
                if (in_data.in_char == bhd_pkg::CHAR_BACKSLASH)
                begin
                    emit = 1'b1;
                    emit_byte = bhd_pkg::CHAR_BACKSLASH;
                    mode_step = bhd_pkg::MODE_PLAIN;
                end
                else if (hv[4])
                begin
                    nibble_step = hv[3:0];
                    mode_step = bhd_pkg::MODE_HEX1;
                end
                else
                begin
                    mode_step = bhd_pkg::MODE_ERROR;
                end
            end
            bhd_pkg::MODE_HEX1:
            begin
                if (hv[4])
                begin
                    emit = 1'b1;
                    emit_byte = {nibble_reg, hv[3:0]};
                    nibble_step = '0;
                    mode_step = bhd_pkg::MODE_PLAIN;
                end
                else
                begin
                    mode_step = bhd_pkg::MODE_ERROR;
                end
            end
            bhd_pkg::MODE_DONE:
            begin
                mode_step = bhd_pkg::MODE_DONE;
            end
            default:
            begin
                mode_step = bhd_pkg::MODE_ERROR;
            end
        endcase

        // saturating byte count
        count_step = count_reg;
        if (emit && count_reg != '1)
        begin
            count_step = count_reg + 1'b1;
        end

        push_op.has_byte = emit;
        push_op.data_byte = emit_byte;
        push_op.has_close = in_data.in_last;
        push_op.close_err = !(mode_step == bhd_pkg::MODE_PLAIN ||
                              mode_step == bhd_pkg::MODE_DONE);
        push_op.length = push_op.close_err ? '0 : sat_length(count_step);

        push = accept && (emit || in_data.in_last);

        mode_next = mode_reg;
        nibble_next = nibble_reg;
        count_next = count_reg;
        if (accept)
        begin
            if (in_data.in_last)
            begin
                mode_next = bhd_pkg::MODE_PLAIN;
                nibble_next = '0;
                count_next = '0;
            end
            else
            begin
                mode_next = mode_step;
                nibble_next = nibble_step;
                count_next = count_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= bhd_pkg::MODE_PLAIN;
            nibble_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            nibble_reg <= nibble_next;
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/core/bhd_queue.sv */
module bhd_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  bhd_pkg::op_t            push_op,
    input  logic                    pop,
    output bhd_pkg::op_t            head_op,
    output bhd_pkg::queue_status_t  status,
    output logic [bhd_pkg::QUEUE_CNT_BITS-1:0] level
);

    bhd_pkg::op_t                           entry_reg [bhd_pkg::QUEUE_DEPTH];
    logic [bhd_pkg::QUEUE_PTR_BITS-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [bhd_pkg::QUEUE_PTR_BITS-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [bhd_pkg::QUEUE_CNT_BITS-1:0]     level_reg, level_next;
    logic                                   do_push, do_pop;

    assign status.full = (level_reg == bhd_pkg::QUEUE_CNT_BITS'(bhd_pkg::QUEUE_DEPTH));
    assign status.not_empty = (level_reg != '0);
    assign level = level_reg;
    assign head_op = entry_reg[rd_ptr_reg];

    assign do_push = push && !status.full;
    assign do_pop = pop && status.not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next = level_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg <= level_next;
        end
    end

endmodule

/* rtl/core/bhd_back.sv */
module bhd_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  bhd_pkg::queue_status_t  queue_status,
    input  bhd_pkg::op_t            head_op,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output bhd_pkg::out_item_t      out_data
);

    bhd_pkg::op_t   op_reg, op_next;
    logic           op_valid_reg, op_valid_next;
    logic           byte_sent_reg, byte_sent_next;
    logic           byte_phase;
    logic           op_done;
    logic           load;

    // byte result goes out first when the op carries one
    assign byte_phase = op_reg.has_byte && !byte_sent_reg;
    assign op_done = op_valid_reg && out_ready && !(byte_phase && op_reg.has_close);
    assign load = !op_valid_reg || op_done;
    assign pop = load && queue_status.not_empty;

    assign out_valid = op_valid_reg;

    always_comb
    begin
        if (byte_phase)
        begin
            out_data.out_kind = bhd_pkg::KIND_BYTE;
            out_data.out_byte = op_reg.data_byte;
            out_data.out_length = '0;
            out_data.out_end = 1'b0;
        end
        else
        begin
            out_data.out_kind = op_reg.close_err ? bhd_pkg::KIND_ERR : bhd_pkg::KIND_OK;
            out_data.out_byte = '0;
            out_data.out_length = op_reg.length;
            out_data.out_end = 1'b1;
        end
    end

    always_comb
    begin
        op_next = op_reg;
        op_valid_next = op_valid_reg;
        byte_sent_next = byte_sent_reg;
        if (load)
        begin
            op_next = head_op;
            op_valid_next = queue_status.not_empty;
            byte_sent_next = 1'b0;
        end
        else if (op_valid_reg && out_ready)
        begin
            byte_sent_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg <= 1'b0;
            byte_sent_reg <= 1'b0;
        end
        else
        begin
            op_valid_reg <= op_valid_next;
            byte_sent_reg <= byte_sent_next;
        end
    end

endmodule

/* rtl/core/backslash_hex_escape_decoder_core.sv */
// ops pass through the queue, then the back end op register, before out_valid rises
// throughput: one character per cycle while the queue is not full; a last character that
//   also yields a byte needs two output transfers
// a 4-entry op queue sits between the decode front and the output back end
// reset: rst_n is asynchronous, active low; clears decode state, queue and output valid
module backslash_hex_escape_decoder_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bhd_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output bhd_pkg::out_item_t  out_data
);

    // front to queue
    logic                                   push;
    bhd_pkg::op_t                           push_op;

    // queue to back
    logic                                   pop;
    bhd_pkg::op_t                           head_op;
    bhd_pkg::queue_status_t                 queue_status;
    logic [bhd_pkg::QUEUE_CNT_BITS-1:0]     queue_level;

    // decode state machine: escapes, hex pairs, terminator and error tracking
    bhd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .queue_status (queue_status),
        .push         (push),
        .push_op      (push_op)
    );

    // short queue lets the front keep taking characters while the output stalls
    bhd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_op  (push_op),
        .pop      (pop),
        .head_op  (head_op),
        .status   (queue_status),
        .level    (queue_level)
    );

    // splits each op into a byte result and/or a closing result
    bhd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_status (queue_status),
        .head_op      (head_op),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data)
    );

`ifndef SYNTHESIS
    // queue never holds more than its depth
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        queue_level <= bhd_pkg::QUEUE_CNT_BITS'(bhd_pkg::QUEUE_DEPTH))
        else $error("op queue overflow");

    // front is stalled only when the queue is really full
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> queue_level == bhd_pkg::QUEUE_CNT_BITS'(bhd_pkg::QUEUE_DEPTH))
        else $error("input stalled with room in queue");

    // a byte transfer never carries closing information
    a_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.out_kind == bhd_pkg::KIND_BYTE |->
            !out_data.out_end && out_data.out_length == '0)
        else $error("byte result with closing fields");

    // closing transfers always carry the end mark and a closing kind
    a_close_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.out_end |->
            (out_data.out_kind == bhd_pkg::KIND_OK || out_data.out_kind == bhd_pkg::KIND_ERR))
        else $error("closing result with bad kind");
`endif

endmodule

/* tb/sv/tb_backslash_hex_escape_decoder_core.sv */
module tb_backslash_hex_escape_decoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    // generous cycle budget
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int STALL_CYCLES = 200;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    bhd_pkg::in_item_t  in_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    bhd_pkg::out_item_t out_data;

    // characters waiting to be offered, and results the decoder still owes
    bhd_pkg::in_item_t  pending_chars[$];
    bhd_pkg::out_item_t expected_results[$];

    // idle percentages per side, changed between phases at a falling edge
    int send_idle = 38;
    int recv_idle = 66;

    // one long receiver hold-off while the sender keeps offering
    logic stall_req = 1'b0;
    logic stall_done = 1'b0;
    int   stall_left = 0;

    int error_count = 0;
    int cycle_cnt = 0;

    // mirror of the decoder state
    bhd_pkg::mode_t                  dec_mode = bhd_pkg::MODE_PLAIN;
    logic [3:0]                      dec_nibble = '0;
    logic [bhd_pkg::LENGTH_BITS-1:0] dec_count = '0;

    backslash_hex_escape_decoder_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #6 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // value of a hex digit character, -1 when it is not one
    function automatic int digit_value(input logic [7:0] c);
        if (c inside {[bhd_pkg::CHAR_DIGIT_0:bhd_pkg::CHAR_DIGIT_9]})
        begin
            return int'(c) - int'(bhd_pkg::CHAR_DIGIT_0);
        end
        if (c inside {[bhd_pkg::CHAR_UPPER_A:bhd_pkg::CHAR_UPPER_F]})
        begin
            return int'(c) - int'(bhd_pkg::CHAR_UPPER_A) + 10;
        end
        if (c inside {[bhd_pkg::CHAR_LOWER_A:bhd_pkg::CHAR_LOWER_F]})
        begin
            return int'(c) - int'(bhd_pkg::CHAR_LOWER_A) + 10;
        end
        return -1;
    endfunction

    task automatic emit_byte(input logic [7:0] b);
        bhd_pkg::out_item_t r;
        r = '0;
        r.out_kind = bhd_pkg::KIND_BYTE;
        r.out_byte = b;
        expected_results.push_back(r);
        // counter sticks at all ones
        if (dec_count != '1)
        begin
            dec_count = dec_count + 1'b1;
        end
    endtask

    // expected results for one transferred character
    task automatic decode_char(input bhd_pkg::in_item_t item);
        int                 dv;
        bhd_pkg::out_item_t r;
        dv = digit_value(item.in_char);
        case (dec_mode)
            bhd_pkg::MODE_PLAIN:
            begin
                if (item.in_char == bhd_pkg::CHAR_NUL)
                begin
                    dec_mode = bhd_pkg::MODE_DONE;
                end
                else if (item.in_char == bhd_pkg::CHAR_BACKSLASH)
                begin
                    dec_mode = bhd_pkg::MODE_ESC;
                end
                else
                begin
                    emit_byte(item.in_char);
                end
            end
            bhd_pkg::MODE_ESC:
            begin
                if (item.in_char == bhd_pkg::CHAR_BACKSLASH)
                begin
                    emit_byte(bhd_pkg::CHAR_BACKSLASH);
                    dec_mode = bhd_pkg::MODE_PLAIN;
                end
                else if (dv >= 0)
                begin
                    dec_nibble = 4'(dv);
                    dec_mode = bhd_pkg::MODE_HEX1;
                end
                else
                begin
                    dec_mode = bhd_pkg::MODE_ERROR;
                end
            end
            bhd_pkg::MODE_HEX1:
            begin
                if (dv >= 0)
                begin
                    emit_byte({dec_nibble, 4'(dv)});
                    dec_nibble = '0;
                    dec_mode = bhd_pkg::MODE_PLAIN;
                end
                else
                begin
                    dec_mode = bhd_pkg::MODE_ERROR;
                end
            end
            bhd_pkg::MODE_DONE:
            begin
            end
            default:
            begin
                dec_mode = bhd_pkg::MODE_ERROR;
            end
        endcase

        // closing result on the last character, then back to a fresh string
        if (item.in_last)
        begin
            r = '0;
            r.out_end = 1'b1;
            if (dec_mode == bhd_pkg::MODE_PLAIN || dec_mode == bhd_pkg::MODE_DONE)
            begin
                r.out_kind = bhd_pkg::KIND_OK;
                if (64'(dec_count) > 64'(16'hFFFF))
                begin
                    r.out_length = '1;
                end
                else
                begin
                    r.out_length = bhd_pkg::OUT_LENGTH_BITS'(dec_count);
                end
            end
            else
            begin
                r.out_kind = bhd_pkg::KIND_ERR;
            end
            expected_results.push_back(r);
            dec_mode = bhd_pkg::MODE_PLAIN;
            dec_nibble = '0;
            dec_count = '0;
        end
    endtask

    // driver: offer the next pending character, hold it until the transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
            begin
                decode_char(in_data);
            end
            if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle)
            begin
                in_data <= pending_chars.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // hold-off counter, armed once from the stimulus
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_left <= 0;
            stall_done <= 1'b0;
        end
        else if (stall_req && !stall_done)
        begin
            stall_left <= STALL_CYCLES;
            stall_done <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
        end
    end

    // monitor: check each result transfer against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        bhd_pkg::out_item_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result kind %0d byte %02h len %0d end %0b",
                        out_data.out_kind, out_data.out_byte, out_data.out_length,
                        out_data.out_end));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.out_kind !== want.out_kind)
                    begin
                        report_mismatch($sformatf("out_kind %0d, want %0d",
                            out_data.out_kind, want.out_kind));
                    end
                    if (out_data.out_byte !== want.out_byte)
                    begin
                        report_mismatch($sformatf("out_byte %02h, want %02h",
                            out_data.out_byte, want.out_byte));
                    end
                    if (out_data.out_length !== want.out_length)
                    begin
                        report_mismatch($sformatf("out_length %0d, want %0d",
                            out_data.out_length, want.out_length));
                    end
                    if (out_data.out_end !== want.out_end)
                    begin
                        report_mismatch($sformatf("out_end %0b, want %0b",
                            out_data.out_end, want.out_end));
                    end
                end
            end
            out_ready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic add_char(input logic [7:0] c, input logic last);
        bhd_pkg::in_item_t item;
        item.in_char = c;
        item.in_last = last;
        pending_chars.push_back(item);
    endtask

    // any character that passes straight through
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
        begin
            c = 8'($urandom_range(1, 255));
        end
        while (c == bhd_pkg::CHAR_BACKSLASH);
        return c;
    endfunction

    // hex digit in either case
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
        begin
            return bhd_pkg::CHAR_DIGIT_0 + 8'(n);
        end
        if ($urandom_range(1) == 1)
        begin
            return bhd_pkg::CHAR_UPPER_A + 8'(n) - 8'd10;
        end
        return bhd_pkg::CHAR_LOWER_A + 8'(n) - 8'd10;
    endfunction

    // anything that may not follow a backslash, zero included
    function automatic logic [7:0] bad_escape_char();
        logic [7:0] c;
        do
        begin
            c = 8'($urandom_range(0, 255));
        end
        while (c == bhd_pkg::CHAR_BACKSLASH || digit_value(c) >= 0);
        return c;
    endfunction

    // one string: mostly well-formed escapes, some noise, sometimes a broken tail
    task automatic add_string();
        int                tokens;
        int                pick;
        logic [7:0]        val;
        bhd_pkg::in_item_t tail;
        tokens = $urandom_range(1, 10);
        for (int t = 0; t < tokens; t++)
        begin
            pick = $urandom_range(99);
            val = 8'($urandom);
            if (pick < 45)
            begin
                add_char(plain_char(), 1'b0);
            end
            else if (pick < 55)
            begin
                add_char(bhd_pkg::CHAR_BACKSLASH, 1'b0);
                add_char(bhd_pkg::CHAR_BACKSLASH, 1'b0);
            end
            else if (pick < 80)
            begin
                add_char(bhd_pkg::CHAR_BACKSLASH, 1'b0);
                add_char(hex_char(val[7:4]), 1'b0);
                add_char(hex_char(val[3:0]), 1'b0);
            end
            else if (pick < 88)
            begin
                add_char(val, 1'b0);
            end
            else if (pick < 92)
            begin
                add_char(bhd_pkg::CHAR_NUL, 1'b0);
            end
            else
            begin
                add_char(bhd_pkg::CHAR_BACKSLASH, 1'b0);
                add_char(bad_escape_char(), 1'b0);
            end
        end
        // escape cut off by the end of the string
        pick = $urandom_range(99);
        if (pick < 6)
        begin
            add_char(bhd_pkg::CHAR_BACKSLASH, 1'b0);
        end
        else if (pick < 10)
        begin
            add_char(bhd_pkg::CHAR_BACKSLASH, 1'b0);
            add_char(hex_char(4'($urandom_range(15))), 1'b0);
        end
        tail = pending_chars.pop_back();
        tail.in_last = 1'b1;
        pending_chars.push_back(tail);
    endtask

    task automatic add_random(input int count);
        int start;
        start = pending_chars.size();
        while (pending_chars.size() - start < count)
        begin
            add_string();
        end
    endtask

    task automatic wait_sent();
        while (pending_chars.size() != 0 || in_valid)
        begin
            @(negedge clk);
        end
    endtask

    // timeout watchdog
    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("tb_backslash_hex_escape_decoder_core NOT OK");
        $finish;
    end

    initial
    begin
        // plain byte FF, doubled backslash, hex in both cases,
        // then byte and closing result on the same last character
        add_char(8'hFF, 1'b0);
        add_char(bhd_pkg::CHAR_BACKSLASH, 1'b0);
        add_char(bhd_pkg::CHAR_BACKSLASH, 1'b0);
        add_char(bhd_pkg::CHAR_BACKSLASH, 1'b0);
        add_char("4", 1'b0);
        add_char("a", 1'b0);
        add_char(bhd_pkg::CHAR_BACKSLASH, 1'b0);
        add_char("F", 1'b0);
        add_char("0", 1'b0);
        add_char(bhd_pkg::CHAR_BACKSLASH, 1'b0);
        add_char("0", 1'b0);
        add_char("9", 1'b1);
        // escape cut off after the backslash and after one digit
        add_char(bhd_pkg::CHAR_BACKSLASH, 1'b1);
        add_char(bhd_pkg::CHAR_BACKSLASH, 1'b0);
        add_char("7", 1'b1);
        // zero inside an escape is an error, later characters ignored
        add_char(bhd_pkg::CHAR_BACKSLASH, 1'b0);
        add_char(bhd_pkg::CHAR_NUL, 1'b0);
        add_char("x", 1'b1);
        // non-hex after the backslash
        add_char(bhd_pkg::CHAR_BACKSLASH, 1'b0);
        add_char("g", 1'b1);
        // terminator hides a broken escape behind it
        add_char("h", 1'b0);
        add_char(bhd_pkg::CHAR_NUL, 1'b0);
        add_char(bhd_pkg::CHAR_BACKSLASH, 1'b0);
        add_char("q", 1'b1);
        // empty string
        add_char(bhd_pkg::CHAR_NUL, 1'b1);

        add_random(480);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // sender lightly idle, receiver mostly stalled
        wait_sent();

        send_idle = 66;
        recv_idle = 38;
        add_random(500);
        wait_sent();

        // no idling; long hold-off first so the queue fills and in_ready drops
        send_idle = 0;
        recv_idle = 0;
        stall_req = 1'b1;
        add_random(500);
        wait_sent();

        while (expected_results.size() != 0)
        begin
            @(negedge clk);
        end
        // leave room for any stray result
        repeat (8) @(negedge clk);

        if (error_count == 0)
        begin
            $display("tb_backslash_hex_escape_decoder_core OK");
        end
        else
        begin
            $display("tb_backslash_hex_escape_decoder_core NOT OK");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/bhd_pkg.sv
rtl/core/bhd_front.sv
rtl/core/bhd_queue.sv
rtl/core/bhd_back.sv
rtl/core/backslash_hex_escape_decoder_core.sv
tb/sv/tb_backslash_hex_escape_decoder_core.sv
